FILE: sv/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked only outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_ALWAYS(label, prop)
`endif
`endif

FILE: sv/mte_pkg.sv
// Types, constants and helper functions for the MIDI track event parser.
package mte_pkg;

  localparam int TIME_BITS = 32;
  localparam int LEN_BITS = 28;
  localparam int SUM_BITS = ((TIME_BITS > LEN_BITS) ? TIME_BITS : LEN_BITS) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS = 2;
  localparam int CNT_BITS = 3;

  localparam logic [7:0] OP_MASK     = 8'hf0;
  localparam logic [7:0] OP_NOTE_OFF = 8'h80;
  localparam logic [7:0] OP_NOTE_ON  = 8'h90;
  localparam logic [7:0] OP_PROGRAM  = 8'hc0;
  localparam logic [7:0] OP_PRESSURE = 8'hd0;
  localparam logic [7:0] VEL_RELEASE = 8'h40;
  localparam logic [7:0] LEAD_SYSEX  = 8'hf0;
  localparam logic [7:0] LEAD_ESCAPE = 8'hf7;
  localparam logic [7:0] LEAD_META   = 8'hff;

  typedef enum logic [2:0] {
    PH_DELAY,
    PH_LEAD,
    PH_FIRST,
    PH_SECOND,
    PH_MTYPE,
    PH_LEN,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [2:0] {
    KIND_CHANNEL,
    KIND_HEADER,
    KIND_PAYLOAD,
    KIND_END,
    KIND_TRUNCATED,
    KIND_BAD_LEAD,
    KIND_BAD_DELAY
  } kind_t;

  typedef struct packed {
    logic [7:0] track_byte;
    logic       end_of_track;
  } byte_item_t;

  typedef struct packed {
    kind_t               kind;
    logic [31:0]         tick_time;
    logic [7:0]          status_code;
    logic [3:0]          channel;
    logic [7:0]          first_data;
    logic [7:0]          second_data;
    logic [LEN_BITS-1:0] payload_length;
    logic                last_result;
  } evt_item_t;

  // Saturating add of a delta onto the track time.
  function automatic logic [TIME_BITS-1:0] time_add(logic [TIME_BITS-1:0] t,
                                                    logic [LEN_BITS-1:0] d);
    logic [SUM_BITS-1:0] s;
    s = SUM_BITS'(t) + SUM_BITS'(d);
    if (s > SUM_BITS'(TIME_MAX)) begin
      return TIME_MAX;
    end else begin
      return s[TIME_BITS-1:0];
    end
  endfunction

  // Low 32 bits of the track time, zero extended when narrower.
  function automatic logic [31:0] tick_of(logic [TIME_BITS-1:0] t);
    logic [TIME_BITS+31:0] w;
    w = {32'd0, t};
    return w[31:0];
  endfunction

  function automatic logic one_data(logic [7:0] lead);
    return ((lead & OP_MASK) == OP_PROGRAM) || ((lead & OP_MASK) == OP_PRESSURE);
  endfunction

  // Channel event; note on with zero velocity reads as note off.
  function automatic evt_item_t chan_result(logic [7:0] lead, logic [7:0] a,
                                            logic [7:0] b);
    evt_item_t r;
    r = '0;
    r.kind = KIND_CHANNEL;
    r.channel = lead[3:0];
    r.status_code = lead;
    r.first_data = a;
    r.second_data = b;
    if ((lead & OP_MASK) == OP_NOTE_ON && b == 8'd0) begin
      r.status_code = OP_NOTE_OFF | {4'd0, lead[3:0]};
      r.second_data = VEL_RELEASE;
    end
    return r;
  endfunction

endpackage

FILE: sv/midi_track_event_parser.sv
// MIDI track chunk byte parser: delta times, running status, meta/sysex, end report.
//
//   channel   dir  payload                 handshake
//   byte_*    in   mte_pkg::byte_item_t    byte_valid / byte_ready
//   evt_*     out  mte_pkg::evt_item_t     evt_valid / evt_ready
//
// One byte is taken per cycle while byte_ready is high; its parse and state update are done in that cycle.
// Each byte gives zero, one or two results into a four-entry result queue.
// byte_ready is high while the queue has room for two results.
// Results leave one per cycle while evt_ready is high; a queue entry is visible the cycle after its byte.
// rst is synchronous and clears parser state and the queue.
`include "assert_macros.svh"

module midi_track_event_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  mte_pkg::byte_item_t  byte_item,
  output logic                 evt_valid,
  input  logic                 evt_ready,
  output mte_pkg::evt_item_t   evt_item
);

  mte_pkg::phase_t                  phase, phase_next;
  logic [7:0]                       running_status, running_status_next;
  logic [7:0]                       current_lead, current_lead_next;
  logic [7:0]                       first_byte_hold, first_byte_hold_next;
  logic [mte_pkg::LEN_BITS-1:0]     vlq_acc, vlq_acc_next;
  logic [2:0]                       vlq_cnt, vlq_cnt_next;
  logic [mte_pkg::TIME_BITS-1:0]    track_time, track_time_next;
  logic [mte_pkg::LEN_BITS-1:0]     payload_remaining, payload_remaining_next;
  logic                             track_stopped, track_stopped_next;

  mte_pkg::evt_item_t               queue [mte_pkg::FIFO_DEPTH];
  logic [mte_pkg::PTR_BITS-1:0]     wptr, rptr;
  logic [mte_pkg::CNT_BITS-1:0]     count;

  mte_pkg::evt_item_t               res0, res1;
  logic [1:0]                       push_n;
  logic                             accept, pop;

  logic [7:0]                       b;
  logic [mte_pkg::LEN_BITS-1:0]     acc_take;
  logic [2:0]                       cnt_take;
  logic                             vlq_done, vlq_bad;
  logic [mte_pkg::TIME_BITS-1:0]    time_upd;
  mte_pkg::kind_t                   end_kind;

  assign accept = byte_valid && byte_ready;
  assign pop = evt_valid && evt_ready;
  assign byte_ready = (count <= mte_pkg::CNT_BITS'(mte_pkg::FIFO_DEPTH - 2));
  assign evt_valid = (count != '0);
  assign evt_item = queue[rptr];

  assign b = byte_item.track_byte;
  assign acc_take = {vlq_acc[mte_pkg::LEN_BITS-8:0], b[6:0]};
  assign cnt_take = vlq_cnt + 3'd1;
  assign vlq_done = !b[7];
  assign vlq_bad = b[7] && (cnt_take >= 3'd4);

  always_comb begin
    phase_next = phase;
    running_status_next = running_status;
    current_lead_next = current_lead;
    first_byte_hold_next = first_byte_hold;
    vlq_acc_next = vlq_acc;
    vlq_cnt_next = vlq_cnt;
    time_upd = track_time;
    payload_remaining_next = payload_remaining;
    track_stopped_next = track_stopped;
    res0 = '0;
    res1 = '0;
    push_n = 2'd0;
    end_kind = mte_pkg::KIND_END;

    if (!track_stopped) begin
      unique case (phase)
        mte_pkg::PH_DELAY: begin
          vlq_acc_next = acc_take;
          vlq_cnt_next = cnt_take;
          if (vlq_done) begin
            time_upd = mte_pkg::time_add(track_time, acc_take);
            vlq_acc_next = '0;
            vlq_cnt_next = '0;
            phase_next = mte_pkg::PH_LEAD;
          end else if (vlq_bad) begin
            res0.kind = mte_pkg::KIND_BAD_DELAY;
            push_n = 2'd1;
            track_stopped_next = 1'b1;
          end
        end
        mte_pkg::PH_LEAD: begin
          if (b[7]) begin
            if (b < mte_pkg::LEAD_SYSEX) begin
              current_lead_next = b;
              running_status_next = b;
              phase_next = mte_pkg::PH_FIRST;
            end else if (b == mte_pkg::LEAD_META || b == mte_pkg::LEAD_SYSEX ||
                         b == mte_pkg::LEAD_ESCAPE) begin
              current_lead_next = b;
              running_status_next = '0;
              vlq_acc_next = '0;
              vlq_cnt_next = '0;
              first_byte_hold_next = '0;
              phase_next = (b == mte_pkg::LEAD_META) ? mte_pkg::PH_MTYPE
                                                      : mte_pkg::PH_LEN;
            end else begin
              running_status_next = '0;
              res0.kind = mte_pkg::KIND_BAD_LEAD;
              res0.status_code = b;
              push_n = 2'd1;
              track_stopped_next = 1'b1;
            end
          end else if (running_status != '0) begin
            current_lead_next = running_status;
            if (mte_pkg::one_data(running_status)) begin
              res0 = mte_pkg::chan_result(running_status, b, 8'd0);
              push_n = 2'd1;
              phase_next = mte_pkg::PH_DELAY;
            end else begin
              first_byte_hold_next = b;
              phase_next = mte_pkg::PH_SECOND;
            end
          end else begin
            res0.kind = mte_pkg::KIND_BAD_LEAD;
            res0.status_code = b;
            push_n = 2'd1;
            track_stopped_next = 1'b1;
          end
        end
        mte_pkg::PH_FIRST: begin
          if (mte_pkg::one_data(current_lead)) begin
            res0 = mte_pkg::chan_result(current_lead, b, 8'd0);
            push_n = 2'd1;
            phase_next = mte_pkg::PH_DELAY;
          end else begin
            first_byte_hold_next = b;
            phase_next = mte_pkg::PH_SECOND;
          end
        end
        mte_pkg::PH_SECOND: begin
          res0 = mte_pkg::chan_result(current_lead, first_byte_hold, b);
          push_n = 2'd1;
          phase_next = mte_pkg::PH_DELAY;
        end
        mte_pkg::PH_MTYPE: begin
          first_byte_hold_next = b;
          phase_next = mte_pkg::PH_LEN;
        end
        mte_pkg::PH_LEN: begin
          vlq_acc_next = acc_take;
          vlq_cnt_next = cnt_take;
          if (vlq_done) begin
            payload_remaining_next = acc_take;
            res0.kind = mte_pkg::KIND_HEADER;
            res0.status_code = current_lead;
            res0.first_data = first_byte_hold;
            res0.payload_length = acc_take;
            push_n = 2'd1;
            vlq_acc_next = '0;
            vlq_cnt_next = '0;
            phase_next = (acc_take != '0) ? mte_pkg::PH_PAYLOAD : mte_pkg::PH_DELAY;
          end else if (vlq_bad) begin
            res0.kind = mte_pkg::KIND_BAD_DELAY;
            res0.status_code = current_lead;
            push_n = 2'd1;
            track_stopped_next = 1'b1;
          end
        end
        mte_pkg::PH_PAYLOAD: begin
          payload_remaining_next = payload_remaining - 1'b1;
          res0.kind = mte_pkg::KIND_PAYLOAD;
          res0.status_code = current_lead;
          res0.first_data = b;
          res0.payload_length = payload_remaining_next;
          push_n = 2'd1;
          if (payload_remaining_next == '0) begin
            phase_next = mte_pkg::PH_DELAY;
          end
        end
        default: begin
          phase_next = mte_pkg::PH_DELAY;
        end
      endcase
    end

    if (byte_item.end_of_track) begin
      if (!track_stopped_next) begin
        if (phase_next == mte_pkg::PH_DELAY) begin
          end_kind = (vlq_cnt_next != '0) ? mte_pkg::KIND_BAD_DELAY : mte_pkg::KIND_END;
        end else if (phase_next == mte_pkg::PH_LEAD) begin
          end_kind = mte_pkg::KIND_END;
        end else begin
          end_kind = mte_pkg::KIND_TRUNCATED;
        end
        if (push_n == 2'd0) begin
          res0 = '0;
          res0.kind = end_kind;
          push_n = 2'd1;
        end else begin
          res1.kind = end_kind;
          push_n = 2'd2;
        end
      end
    end

    res0.tick_time = mte_pkg::tick_of(time_upd);
    res1.tick_time = mte_pkg::tick_of(time_upd);
    if (push_n == 2'd1) begin
      res0.last_result = 1'b1;
    end
    if (push_n == 2'd2) begin
      res1.last_result = 1'b1;
    end
    track_time_next = time_upd;

    // Final byte: back to reset for the next chunk.
    if (byte_item.end_of_track) begin
      phase_next = mte_pkg::PH_DELAY;
      running_status_next = '0;
      current_lead_next = '0;
      first_byte_hold_next = '0;
      vlq_acc_next = '0;
      vlq_cnt_next = '0;
      track_time_next = '0;
      payload_remaining_next = '0;
      track_stopped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= mte_pkg::PH_DELAY;
      running_status <= '0;
      current_lead <= '0;
      first_byte_hold <= '0;
      vlq_acc <= '0;
      vlq_cnt <= '0;
      track_time <= '0;
      payload_remaining <= '0;
      track_stopped <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      running_status <= running_status_next;
      current_lead <= current_lead_next;
      first_byte_hold <= first_byte_hold_next;
      vlq_acc <= vlq_acc_next;
      vlq_cnt <= vlq_cnt_next;
      track_time <= track_time_next;
      payload_remaining <= payload_remaining_next;
      track_stopped <= track_stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push_n != 2'd0) begin
      queue[wptr] <= res0;
    end
    if (accept && push_n == 2'd2) begin
      queue[wptr + 1'b1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (accept) begin
        wptr <= wptr + mte_pkg::PTR_BITS'(push_n);
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (accept ? mte_pkg::CNT_BITS'(push_n) : '0)
                     - mte_pkg::CNT_BITS'(pop);
    end
  end

  `ASSERT_CLK(a_queue_bound, count <= mte_pkg::CNT_BITS'(mte_pkg::FIFO_DEPTH))
  `ASSERT_CLK(a_vlq_bound, vlq_cnt <= 3'd4)
  `ASSERT_CLK(a_stopped_silent,
    accept && track_stopped && !byte_item.end_of_track |-> push_n == 2'd0)
  `ASSERT_CLK(a_second_emits,
    accept && !track_stopped && phase == mte_pkg::PH_SECOND |-> push_n != 2'd0)
  `ASSERT_CLK(a_end_resets,
    accept && byte_item.end_of_track |=> phase == mte_pkg::PH_DELAY &&
    track_time == '0 && !track_stopped && running_status == '0)

endmodule
